>>> rtl/vertex_texture_quantizer_unit_macros.svh
// ----------------------------------------------------------------------------
// vertex texture quantizer assertion macros
// Short forms for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TEXTURE_QUANTIZER_UNIT_MACROS_SVH
`define VERTEX_TEXTURE_QUANTIZER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define VTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vtq_pkg.sv
// ----------------------------------------------------------------------------
// vtq_pkg
// Shared types and constants of the vertex texture quantizer.
// ----------------------------------------------------------------------------
package vtq_pkg;

    // default sizes
    localparam int VTQ_MAX_VERTS  = 4096;
    localparam int VTQ_MAX_FRAMES = 256;

    // command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_POS  = 2'd1;
    localparam logic [1:0] CMD_NRM  = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_MIN_X       = 3'd0;
    localparam logic [2:0] CFG_MIN_Y       = 3'd1;
    localparam logic [2:0] CFG_MIN_Z       = 3'd2;
    localparam logic [2:0] CFG_MAX_X       = 3'd3;
    localparam logic [2:0] CFG_MAX_Y       = 3'd4;
    localparam logic [2:0] CFG_MAX_Z       = 3'd5;
    localparam logic [2:0] CFG_VERTEX_TOTAL = 3'd6;
    localparam logic [2:0] CFG_FRAME_TOTAL  = 3'd7;

    // lane pipeline: one prep stage then one quotient bit per stage
    localparam int DIV_STEPS  = 16;
    localparam int LANE_DEPTH = DIV_STEPS + 1;
    localparam int NUM_W      = 50;
    localparam int DEN_W      = 34;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         frame;
        logic [11:0]        column;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [11:0]        perm_target;
    } t_in_item;

    typedef struct packed {
        logic [20:0] texel_index;
        logic [15:0] chan_r;
        logic [15:0] chan_g;
        logic [15:0] chan_b;
        logic        status;
    } t_out_item;

    // per-axis work handed to a lane
    typedef struct packed {
        logic               is_nrm;
        logic signed [31:0] coord;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_lane_in;

    // per-item data that travels beside the lanes
    typedef struct packed {
        logic        status;
        logic [20:0] texel_index;
    } t_side;

endpackage

>>> rtl/vtq_lane.sv
// ----------------------------------------------------------------------------
// vtq_lane
// One axis: position scaling through a pipelined restoring divider,
// or the normal mapping, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtq_lane import vtq_pkg::*; (
    input  logic                  i_clk,
    input  t_lane_in              i_lane,
    input  logic [LANE_DEPTH-1:0] i_adv,
    output logic [15:0]           o_q
);

    logic signed [32:0] s;
    logic signed [32:0] d;
    logic signed [32:0] t;
    logic [17:0]        m;
    logic [34:0]        mm;
    logic [34:0]        nsum;
    logic [NUM_W-1:0]   dn;
    logic               pos_zero;
    logic               pos_sat;
    logic               n_frc;
    logic [15:0]        n_fval;
    logic [NUM_W-1:0]   n_num;
    logic [DEN_W-1:0]   n_den;

    logic [NUM_W-1:0] r_rem  [LANE_DEPTH];
    logic [DEN_W-1:0] r_den  [LANE_DEPTH];
    logic [15:0]      r_q    [LANE_DEPTH];
    logic             r_frc  [LANE_DEPTH];
    logic [15:0]      r_fval [LANE_DEPTH];

    // span, offset, clamps and the normal mapping
    always_comb begin
        s        = {i_lane.hi[31], i_lane.hi} - {i_lane.lo[31], i_lane.lo};
        d        = {i_lane.coord[31], i_lane.coord} - {i_lane.lo[31], i_lane.lo};
        pos_zero = (s <= 33'sd0) || (d <= 33'sd0);
        pos_sat  = (d >= s);
        dn       = NUM_W'(d[31:0]);
        n_num    = (dn << 17) - (dn << 1) + NUM_W'(s[32:0]);
        n_den    = {s[32:0], 1'b0};
        t        = {i_lane.coord[31], i_lane.coord} + 33'sd65536;
        if (t < 33'sd0) begin
            m = 18'd0;
        end else if (t > 33'sd131072) begin
            m = 18'd131072;
        end else begin
            m = t[17:0];
        end
        mm   = 35'(m);
        nsum = (mm << 16) - mm + 35'd65536;
        if (i_lane.is_nrm) begin
            n_frc  = 1'b1;
            n_fval = nsum[32:17];
        end else if (pos_zero) begin
            n_frc  = 1'b1;
            n_fval = 16'd0;
        end else if (pos_sat) begin
            n_frc  = 1'b1;
            n_fval = 16'hFFFF;
        end else begin
            n_frc  = 1'b0;
            n_fval = 16'd0;
        end
    end

    // prep stage
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_rem[0]  <= n_num;
            r_den[0]  <= n_den;
            r_q[0]    <= 16'd0;
            r_frc[0]  <= n_frc;
            r_fval[0] <= n_fval;
        end
    end

    // quotient stages, most significant bit first
    for (genvar j = 1; j < LANE_DEPTH; j++) begin : g_step
        localparam int B = DIV_STEPS - j;
        logic [NUM_W-1:0] sh;
        logic             ge;
        assign sh = NUM_W'(r_den[j-1]) << B;
        assign ge = (r_rem[j-1] >= sh);
        always_ff @(posedge i_clk) begin
            if (i_adv[j]) begin
                r_rem[j]  <= ge ? (r_rem[j-1] - sh) : r_rem[j-1];
                r_den[j]  <= r_den[j-1];
                r_q[j]    <= r_q[j-1] | (ge ? (16'd1 << B) : 16'd0);
                r_frc[j]  <= r_frc[j-1];
                r_fval[j] <= r_fval[j-1];
            end
        end
    end

    assign o_q = r_frc[LANE_DEPTH-1] ? r_fval[LANE_DEPTH-1] : r_q[LANE_DEPTH-1];

endmodule

>>> rtl/vtq_merge.sv
// ----------------------------------------------------------------------------
// vtq_merge
// Joins the three lane results with the texel index into the output item.
// ----------------------------------------------------------------------------
module vtq_merge import vtq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_adv,
    input  t_side       i_side,
    input  logic [15:0] i_q_r,
    input  logic [15:0] i_q_g,
    input  logic [15:0] i_q_b,
    output t_out_item   o_item
);

    t_out_item n_item;
    t_out_item r_item;

    // out-of-range items carry a zero texel index and zero channels
    always_comb begin
        n_item.status      = i_side.status;
        n_item.texel_index = i_side.status ? 21'd0 : i_side.texel_index;
        n_item.chan_r      = i_side.status ? 16'd0 : i_q_r;
        n_item.chan_g      = i_side.status ? 16'd0 : i_q_g;
        n_item.chan_b      = i_side.status ? 16'd0 : i_q_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> rtl/vertex_texture_quantizer_unit.sv
// ----------------------------------------------------------------------------
// vertex_texture_quantizer_unit
// Quantizes vertex samples to 16-bit texels and gives their texel index.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with one t_in_item. A load item
// writes one column permutation entry and gives no result; a position or
// normal item gives exactly one output item on o_out_valid / i_out_stall.
// From acceptance to o_out_valid an item passes one input stage, one prep
// stage, sixteen divider stages (one quotient bit each, per axis lane) and
// the output register. Throughput is one item per cycle while the receiver
// does not stall; the divider pipeline is the unit that sets the depth.
// When the receiver stalls, the pipeline closes its empty stages and keeps
// taking items until every stage is full, then raises o_in_stall.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index and data;
// write only while the block is idle.
// Reset clears the registers to their defaults, empties the pipeline and
// returns the column mapping to identity; the permutation memory itself is
// not cleared.
// ----------------------------------------------------------------------------
`include "vertex_texture_quantizer_unit_macros.svh"

module vertex_texture_quantizer_unit import vtq_pkg::*; #(
    parameter int MAX_VERTS  = VTQ_MAX_VERTS,
    parameter int MAX_FRAMES = VTQ_MAX_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW   = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW   = (AW > 12) ? AW : 12;
    localparam int NSTG = LANE_DEPTH + 2;

    localparam logic [16:0] MV17 = 17'(MAX_VERTS);
    localparam logic [12:0] MF13 = 13'(MAX_FRAMES);

    // configuration
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic [12:0]        r_vt;
    logic [8:0]         r_ft;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;
    logic            in_acc;
    logic            r_perm_active;

    // input stage
    t_in_item     r_s0;
    logic         r_s0_act;
    logic [11:0]  r_perm_rd;
    logic [11:0]  mem [MAX_VERTS];
    logic [CW-1:0] col_ext;
    logic [AW-1:0] addr;
    logic          col_in_mem;
    logic          is_load;
    logic          is_enc;

    // sideband
    logic [16:0] vt17;
    logic [12:0] vt_eff;
    logic [12:0] ft13;
    logic [8:0]  ft_eff;
    logic [11:0] dst;
    logic [9:0]  row;
    logic [22:0] idx_full;
    t_side       n_side;
    t_side       r_side [LANE_DEPTH];

    t_lane_in    lane_in [3];
    logic [15:0] lane_q  [3];

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min[0] <= 32'sd0;
            r_min[1] <= 32'sd0;
            r_min[2] <= 32'sd0;
            r_max[0] <= 32'sd65536;
            r_max[1] <= 32'sd65536;
            r_max[2] <= 32'sd65536;
            r_vt     <= 13'd4096;
            r_ft     <= 9'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_X:        r_min[0] <= i_cfg_data;
                CFG_MIN_Y:        r_min[1] <= i_cfg_data;
                CFG_MIN_Z:        r_min[2] <= i_cfg_data;
                CFG_MAX_X:        r_max[0] <= i_cfg_data;
                CFG_MAX_Y:        r_max[1] <= i_cfg_data;
                CFG_MAX_Z:        r_max[2] <= i_cfg_data;
                CFG_VERTEX_TOTAL: r_vt     <= i_cfg_data[12:0];
                CFG_FRAME_TOTAL:  r_ft     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves when it is empty or its successor moves
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_stall = !adv[0];
    assign in_acc     = i_in_valid && adv[0];
    assign is_load    = (i_in_item.command == CMD_LOAD);
    assign is_enc     = (i_in_item.command == CMD_POS) || (i_in_item.command == CMD_NRM);
    assign col_ext    = CW'(i_in_item.column);
    assign addr       = col_ext[AW-1:0];
    assign col_in_mem = (17'(i_in_item.column) < MV17);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid && is_enc;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // mapping enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_active <= 1'b0;
        end else if (in_acc && is_load && col_in_mem) begin
            r_perm_active <= 1'b1;
        end
    end

    // permutation memory, written by loads, read by encodes
    always_ff @(posedge i_clk) begin
        if (in_acc && is_load && col_in_mem) begin
            mem[addr] <= i_in_item.perm_target;
        end
        if (in_acc && is_enc) begin
            r_perm_rd <= mem[addr];
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0     <= i_in_item;
            r_s0_act <= r_perm_active;
        end
    end

    // range checks and texel index
    always_comb begin
        vt17     = {4'd0, r_vt};
        vt_eff   = (vt17 > MV17) ? MV17[12:0] : r_vt;
        ft13     = {4'd0, r_ft};
        ft_eff   = (ft13 > MF13) ? MF13[8:0] : r_ft;
        dst      = r_s0_act ? r_perm_rd : r_s0.column;
        row      = (r_s0.command == CMD_NRM) ? (10'(ft_eff) + 10'(r_s0.frame))
                                             : 10'(r_s0.frame);
        idx_full = (23'(row) * 23'(vt_eff)) + 23'(dst);
        n_side.status = ({1'b0, r_s0.frame} >= ft_eff) ||
                        ({1'b0, r_s0.column} >= vt_eff) ||
                        ({1'b0, dst} >= vt_eff);
        n_side.texel_index = idx_full[20:0];
    end

    // sideband beside the lanes
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_side[0] <= n_side;
        end
        for (int k = 1; k < LANE_DEPTH; k++) begin
            if (adv[k+1]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // axis lanes
    always_comb begin
        lane_in[0] = '{is_nrm: (r_s0.command == CMD_NRM), coord: r_s0.coord_x,
                       lo: r_min[0], hi: r_max[0]};
        lane_in[1] = '{is_nrm: (r_s0.command == CMD_NRM), coord: r_s0.coord_y,
                       lo: r_min[1], hi: r_max[1]};
        lane_in[2] = '{is_nrm: (r_s0.command == CMD_NRM), coord: r_s0.coord_z,
                       lo: r_min[2], hi: r_max[2]};
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
        vtq_lane u_lane (
            .i_clk  (i_clk),
            .i_lane (lane_in[a]),
            .i_adv  (adv[LANE_DEPTH:1]),
            .o_q    (lane_q[a])
        );
    end

    // output register
    vtq_merge u_merge (
        .i_clk  (i_clk),
        .i_adv  (adv[NSTG-1]),
        .i_side (r_side[LANE_DEPTH-1]),
        .i_q_r  (lane_q[0]),
        .i_q_g  (lane_q[1]),
        .i_q_b  (lane_q[2]),
        .o_item (o_out_item)
    );

    assign o_out_valid = r_vld[NSTG-1];

    // checks
    `VTQ_ASSERT_IMP(a_bad_zero, o_out_valid && o_out_item.status, (o_out_item.texel_index == 21'd0) && (o_out_item.chan_r == 16'd0) && (o_out_item.chan_g == 16'd0) && (o_out_item.chan_b == 16'd0), "out-of-range item with nonzero fields")
    `VTQ_ASSERT_NXT(a_load_act, in_acc && is_load && col_in_mem, r_perm_active, "load did not enable the mapping")
    `VTQ_ASSERT_IMP(a_out_src, $rose(o_out_valid), $past(r_vld[NSTG-2]), "output item without a source stage")

endmodule
